// File: hdl/ccfr_pkg.sv
// Shared types, constants and the CRC-16/MODBUS byte update for the
// checked frame receiver. No dependencies.
`default_nettype none

package ccfr_pkg;

  localparam int MaxPayload = 511;
  localparam int CntW       = $clog2(MaxPayload + 1);
  localparam int CfgIdxW    = 8;
  localparam int CfgDataW   = 9;

  localparam logic [7:0]  StartByteRst  = 8'h7E;
  localparam logic [8:0]  PayloadLenRst = 9'd69;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcPoly       = 16'hA001;

  localparam logic [CfgIdxW-1:0] RegStartByte  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegPayloadLen = CfgIdxW'(1);

  typedef logic [1:0] kind_t;
  localparam kind_t KindPayload = 2'd0;
  localparam kind_t KindGood    = 2'd1;
  localparam kind_t KindBad     = 2'd2;

  // reflected CRC, one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hdl/crc16_checked_frame_receiver.sv
// Top level of the CRC-16/MODBUS checked frame receiver: frame phase
// tracking, CRC update and a registered result stage. Uses ccfr_pkg.
//
//   channel   signals                                   dir
//   input     in_valid in_ready rx_byte                 in
//   result    out_valid out_ready result_kind
//             byte_offset payload_byte                  out
//   config    cfg_valid cfg_ready cfg_index cfg_data    in
//
// One input beat per cycle unless stalled: phase step and byte-wide CRC update
// are done at the accepting edge; any result lands in the output register.
// in_ready drops only while a result is held and out_ready is low.
// Synchronous reset: hunting, CRC 0xFFFF, registers to 0x7E / 69.
// Config is always ready; out-of-range indexes are ignored.
`default_nettype none

module crc16_checked_frame_receiver (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [7:0]                   rx_byte,
  output logic                         out_valid,
  input  wire                          out_ready,
  output ccfr_pkg::kind_t              result_kind,
  output logic [8:0]                   byte_offset,
  output logic [7:0]                   payload_byte,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [ccfr_pkg::CfgIdxW-1:0] cfg_index,
  input  wire  [ccfr_pkg::CfgDataW-1:0] cfg_data
);
  import ccfr_pkg::*;

  localparam logic [1:0] PhHunt  = 2'd0;
  localparam logic [1:0] PhData  = 2'd1;
  localparam logic [1:0] PhChkLo = 2'd2;
  localparam logic [1:0] PhChkHi = 2'd3;

  logic [7:0]      start_byte;
  logic [8:0]      payload_length;
  logic [1:0]      phase;
  logic [CntW-1:0] count;
  logic [15:0]     crc;
  logic [7:0]      first_chk;

  logic [1:0]      phase_next;
  logic [CntW-1:0] count_next;
  logic [15:0]     crc_next;
  logic [7:0]      first_chk_next;
  logic            res_valid;
  kind_t           res_kind;
  logic [8:0]      res_offset;
  logic [7:0]      res_byte;

  logic [CntW:0]   eff_len;
  logic [CntW:0]   count_inc;
  logic [15:0]     crc_upd;
  logic [15:0]     crc_start;
  logic            in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    if (payload_length == 9'd0) begin
      eff_len = (CntW+1)'(1);
    end else if ({1'b0, payload_length} > 10'(MaxPayload)) begin
      eff_len = (CntW+1)'(MaxPayload);
    end else begin
      eff_len = (CntW+1)'(payload_length);
    end
  end

  assign count_inc = {1'b0, count} + (CntW+1)'(1);
  assign crc_upd   = crc_byte(crc, rx_byte);
  assign crc_start = crc_byte(CrcInit, rx_byte);

  always_comb begin
    phase_next     = phase;
    count_next     = count;
    crc_next       = crc;
    first_chk_next = first_chk;
    res_valid      = 1'b0;
    res_kind       = KindPayload;
    res_offset     = 9'd0;
    res_byte       = 8'd0;
    unique case (phase)
      PhHunt: begin
        count_next = '0;
        if (rx_byte == start_byte) begin
          crc_next   = crc_start;
          phase_next = PhData;
        end
      end
      PhData: begin
        res_valid  = 1'b1;
        res_offset = 9'(count);
        res_byte   = rx_byte;
        crc_next   = crc_upd;
        count_next = count_inc[CntW-1:0];
        if (count_inc >= eff_len) begin
          phase_next = PhChkLo;
        end
      end
      PhChkLo: begin
        first_chk_next = rx_byte;
        phase_next     = PhChkHi;
      end
      PhChkHi: begin
        res_valid  = 1'b1;
        res_kind   = ({rx_byte, first_chk} == crc) ? KindGood : KindBad;
        phase_next = PhHunt;
        count_next = '0;
        crc_next   = CrcInit;
      end
      default: begin
        phase_next = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= StartByteRst;
      payload_length <= PayloadLenRst;
      phase          <= PhHunt;
      count          <= '0;
      crc            <= CrcInit;
      first_chk      <= 8'd0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegStartByte) begin
          start_byte <= cfg_data[7:0];
        end else if (cfg_index == RegPayloadLen) begin
          payload_length <= cfg_data[8:0];
        end
      end
      if (in_fire) begin
        phase     <= phase_next;
        count     <= count_next;
        crc       <= crc_next;
        first_chk <= first_chk_next;
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      result_kind  <= res_kind;
      byte_offset  <= res_offset;
      payload_byte <= res_byte;
    end
  end

  // a byte taken while hunting (dropped, or the start byte) never raises a result
  a_hunt_silent: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PhHunt) |=> !out_valid)
    else $error("result raised while hunting");

  a_verdict_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PhChkHi) |=>
      (phase == PhHunt && crc == CrcInit && count == '0 && out_valid &&
       (result_kind == KindGood || result_kind == KindBad)))
    else $error("verdict did not restart hunting");

  a_verdict_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != KindPayload) |->
      (byte_offset == 9'd0 && payload_byte == 8'd0))
    else $error("verdict carries payload fields");

  a_data_to_check: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PhData) |=> (out_valid && result_kind == KindPayload &&
      (phase == PhData || phase == PhChkLo)))
    else $error("payload beat mishandled");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for crc16_checked_frame_receiver: random and directed byte streams,
// a byte-level predictor of the frame receiver and a scoreboard on the result channel.
// Depends on hdl/ccfr_pkg.sv and hdl/crc16_checked_frame_receiver.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccfr_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int PhaseItems = 60;

  typedef enum logic [1:0] {PhHunt, PhData, PhChkLo, PhChkHi} rx_phase_e;

  typedef struct packed {
    kind_t      kind;
    logic [8:0] offset;
    logic [7:0] data;
  } rx_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          rx_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  kind_t               result_kind;
  logic [8:0]          byte_offset;
  logic [7:0]          payload_byte;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  crc16_checked_frame_receiver u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .byte_offset  (byte_offset),
    .payload_byte (payload_byte),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  logic [7:0]  rx_pending[$];
  logic [7:0]  frame_body[$];
  rx_result_t  result_expect_q[$];

  // predictor state and its copy of the registers
  rx_phase_e   pr_phase;
  logic [11:0] pr_count;
  logic [15:0] pr_crc;
  logic [7:0]  pr_chk_lo;
  logic [7:0]  cf_start;
  logic [8:0]  cf_len;

  logic rx_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int   quiet_cycles = 0;
  int   err_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  function automatic logic [15:0] crc16_modbus_next(input logic [15:0] crc,
                                                    input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [11:0] frame_len(input logic [8:0] n);
    logic [11:0] e;
    e = {3'b000, n};
    if (e == 12'd0) e = 12'd1;
    if (e > 12'(MaxPayload)) e = 12'(MaxPayload);
    return e;
  endfunction

  task automatic predict_rx_byte(input logic [7:0] b);
    rx_result_t r;
    case (pr_phase)
      PhHunt: begin
        pr_count = '0;
        if (b == cf_start) begin
          pr_crc   = crc16_modbus_next(CrcInit, b);
          pr_phase = PhData;
        end
      end
      PhData: begin
        r.kind   = KindPayload;
        r.offset = pr_count[8:0];
        r.data   = b;
        result_expect_q.push_back(r);
        pr_crc   = crc16_modbus_next(pr_crc, b);
        pr_count = pr_count + 12'd1;
        if (pr_count >= frame_len(cf_len)) pr_phase = PhChkLo;
      end
      PhChkLo: begin
        pr_chk_lo = b;
        pr_phase  = PhChkHi;
      end
      default: begin
        r.kind   = ({b, pr_chk_lo} == pr_crc) ? KindGood : KindBad;
        r.offset = '0;
        r.data   = '0;
        result_expect_q.push_back(r);
        pr_phase = PhHunt;
        pr_count = '0;
        pr_crc   = CrcInit;
      end
    endcase
  endtask

  task automatic check_result();
    rx_result_t e;
    if (result_expect_q.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("unexpected beat: kind %0d off %0d byte %02h",
                 result_kind, byte_offset, payload_byte);
    end else begin
      e = result_expect_q.pop_front();
      if (e.kind !== result_kind || e.offset !== byte_offset || e.data !== payload_byte) begin
        err_count++;
        if (err_count <= 10)
          $display("mismatch: exp kind %0d off %0d byte %02h, got kind %0d off %0d byte %02h",
                   e.kind, e.offset, e.data, result_kind, byte_offset, payload_byte);
      end
    end
  endtask

  always @(posedge clk) begin
    rx_taken  <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst) begin
      pr_phase     = PhHunt;
      pr_count     = '0;
      pr_crc       = CrcInit;
      pr_chk_lo    = '0;
      cf_start     = StartByteRst;
      cf_len       = PayloadLenRst;
      quiet_cycles <= 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) predict_rx_byte(rx_byte);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegStartByte:  cf_start = cfg_data[7:0];
          RegPayloadLen: cf_len = cfg_data;
          default: ;
        endcase
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // byte driver and result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || rx_taken) begin
      if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        rx_byte  <= rx_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (rx_pending.size() != 0 || in_valid || result_expect_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // pushes frame_body then its two check bytes, CRC seeded with seed
  task automatic queue_checked(input logic [15:0] seed, input bit corrupt);
    logic [15:0] c;
    c = seed;
    foreach (frame_body[i]) begin
      c = crc16_modbus_next(c, frame_body[i]);
      rx_pending.push_back(frame_body[i]);
    end
    if (corrupt) c = c ^ (16'h0001 << $urandom_range(0, 15));
    rx_pending.push_back(c[7:0]);
    rx_pending.push_back(c[15:8]);
  endtask

  function automatic logic [7:0] rand_payload();
    if ($urandom_range(0, 9) == 0) return cf_start;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      if (b == cf_start) b = b ^ 8'h01;
      rx_pending.push_back(b);
    end
  endtask

  // completes a frame left open before a register change
  task automatic finish_open_frame();
    logic [11:0] left;
    left = (frame_len(cf_len) > pr_count) ? frame_len(cf_len) - pr_count : 12'd1;
    frame_body = {};
    repeat (left) frame_body.push_back(rand_payload());
    queue_checked(pr_crc, $urandom_range(0, 3) == 0);
  endtask

  task automatic run_random_phase(input int p);
    logic [7:0]  s;
    logic [8:0]  n;
    logic [11:0] k;
    int          target;
    case (p)
      3:       begin s = StartByteRst;               n = PayloadLenRst; end
      6:       begin s = 8'($urandom_range(0, 255)); n = 9'(MaxPayload); end
      9:       begin s = 8'hFF;                      n = 9'd0;          end
      10:      begin s = 8'h00;                      n = 9'd2;          end
      default: begin s = 8'($urandom_range(0, 255)); n = 9'($urandom_range(1, 12)); end
    endcase
    wait_drained();
    write_cfg(RegStartByte, {1'b0, s});
    write_cfg(RegPayloadLen, n);
    @(posedge clk);
    send_idle_pct  = (p % 4 == 1) ? 67 : (p % 4 == 3) ? 24 : 0;
    recv_stall_pct = (p % 4 == 2) ? 67 : (p % 4 == 3) ? 24 : 0;
    if (pr_phase == PhData) finish_open_frame();
    target = (p == 6) ? 1 : PhaseItems;
    while (rx_pending.size() < target) begin
      queue_noise($urandom_range(0, 3));
      frame_body = {cf_start};
      repeat (frame_len(cf_len)) frame_body.push_back(rand_payload());
      queue_checked(CrcInit, $urandom_range(0, 9) < 3);
    end
    if ($urandom_range(0, 1) == 1) begin
      k = 12'($urandom_range(0, frame_len(cf_len) - 1));
      rx_pending.push_back(cf_start);
      repeat (k) rx_pending.push_back(rand_payload());
    end
  endtask

  initial begin
    while (quiet_cycles < QuietLimit) @(negedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // hunting noise under reset registers
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(8'h7F);
    wait_drained();
    write_cfg(RegPayloadLen, 9'd1);
    @(posedge clk);
    frame_body = {8'h7E, 8'h00};
    queue_checked(CrcInit, 1'b0);
    frame_body = {8'h7E, 8'h7E};   // start byte as payload, bad check
    queue_checked(CrcInit, 1'b1);
    frame_body = {8'h7E, 8'hFF};
    queue_checked(CrcInit, 1'b0);

    // zero length acts as one; out-of-range indexes dropped
    wait_drained();
    write_cfg(RegStartByte, 9'h0FF);
    write_cfg(RegPayloadLen, 9'd0);
    write_cfg(CfgIdxW'(2), 9'h1FF);
    write_cfg(CfgIdxW'(255), 9'h000);
    @(posedge clk);
    rx_pending.push_back(8'h7E);
    frame_body = {8'hFF, 8'hA5};
    queue_checked(CrcInit, 1'b0);

    // registers changed with a frame open
    wait_drained();
    write_cfg(RegStartByte, 9'h000);
    write_cfg(RegPayloadLen, 9'd3);
    @(posedge clk);
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'h11);
    rx_pending.push_back(8'h22);
    wait_drained();
    write_cfg(RegPayloadLen, 9'd1);
    write_cfg(RegStartByte, 9'h055);
    @(posedge clk);
    finish_open_frame();

    for (int p = 0; p < 12; p++) run_random_phase(p);

    wait_drained();
    repeat (20) @(negedge clk);
    if (result_expect_q.size() != 0) begin
      err_count++;
      $display("%0d expected beats never arrived", result_expect_q.size());
    end
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: crc16_checked_frame_receiver.f
hdl/ccfr_pkg.sv
hdl/crc16_checked_frame_receiver.sv
sim/tb_top.sv
